// ===== sv/best_score_variable_selector_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the best score variable selector
// Shared wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef BEST_SCORE_VARIABLE_SELECTOR_MACROS_SVH
`define BEST_SCORE_VARIABLE_SELECTOR_MACROS_SVH

// check that is switched off while reset is asserted
`define BSSEL_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds across reset
`define BSSEL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bssel_pkg.sv =====
// ----------------------------------------------------------------------------
// bssel_pkg
// Types and fixed field widths of the best score variable selector.
// ----------------------------------------------------------------------------
package bssel_pkg;

    // fixed widths of the input and result fields
    localparam int MODE_BITS      = 2;
    localparam int VAR_INDEX_BITS = 6;
    localparam int DELTA_BITS     = 32;
    localparam int DOMAIN_IN_BITS = 16;
    localparam int SEL_INDEX_BITS = 6;

    // item opcodes
    typedef enum logic [MODE_BITS-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_SELECT = 2'd2
    } t_mode;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // strobes broadcast from the controller to every cell
    typedef struct packed {
        logic load;
        logic adjust;
        logic clear;
    } t_cell_ctrl;

endpackage

// ===== sv/best_score_variable_selector.sv =====
// ----------------------------------------------------------------------------
// best_score_variable_selector
// Variable table with saturating score updates and best-entry selection.
//
// Usage: the input channel (i_in_valid / o_in_ready) takes one word per
// item: a load (mode 0) resets an entry's scores and sets its domain size,
// an adjust (mode 1) adds signed deltas to a remaining entry, a select
// (mode 2) picks the best remaining entry. Mode 3 is taken and dropped.
// Load and adjust words may follow back to back while no select scans.
// A select runs a candidate through the row of NUM_VARS cells, one cell per
// cycle, and no other word is taken until its result word
// (o_selected_index, o_found) goes to an output register on the
// o_out_valid / i_out_ready channel.
// While a result waits in the output register, load and adjust words are
// still taken; a second select finishes its scan and holds until the
// register frees up. Reset clears every remaining flag and the output
// valid flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "best_score_variable_selector_macros.svh"

module best_score_variable_selector #(
    parameter int NUM_VARS    = 64,
    parameter int SCORE_BITS  = 32,
    parameter int DOMAIN_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [bssel_pkg::MODE_BITS-1:0]          i_mode,
    input  logic [bssel_pkg::VAR_INDEX_BITS-1:0]     i_var_index,
    input  logic signed [bssel_pkg::DELTA_BITS-1:0]  i_primary_delta,
    input  logic signed [bssel_pkg::DELTA_BITS-1:0]  i_secondary_delta,
    input  logic [bssel_pkg::DOMAIN_IN_BITS-1:0]     i_domain_size,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [bssel_pkg::SEL_INDEX_BITS-1:0]     o_selected_index,
    output logic                                     o_found
);

    localparam int IW    = $clog2(NUM_VARS);
    localparam int CNT_W = $clog2(NUM_VARS + 1);

    bssel_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    bssel_pkg::t_cell_ctrl w_ctrl;
    logic                  w_in_acc;
    logic                  w_done;

    logic                                    r_out_vld;
    logic [bssel_pkg::SEL_INDEX_BITS-1:0]    r_out_idx;
    logic                                    r_out_found;

    // candidate chain between cells; entry 0 feeds the first cell
    logic                          w_cv [NUM_VARS+1];
    logic signed [SCORE_BITS-1:0]  w_cp [NUM_VARS+1];
    logic signed [SCORE_BITS-1:0]  w_cs [NUM_VARS+1];
    logic [DOMAIN_BITS-1:0]        w_cd [NUM_VARS+1];
    logic [IW-1:0]                 w_ci [NUM_VARS+1];
    logic [NUM_VARS-1:0]           w_flags;

    assign w_cv[0] = 1'b0;
    assign w_cp[0] = '0;
    assign w_cs[0] = '0;
    assign w_cd[0] = '0;
    assign w_ci[0] = '0;

    // row of cells
    for (genvar g = 0; g < NUM_VARS; g++) begin : g_cell
        bssel_cell #(
            .CELL_IDX    (g),
            .NUM_VARS    (NUM_VARS),
            .SCORE_BITS  (SCORE_BITS),
            .DOMAIN_BITS (DOMAIN_BITS)
        ) u_cell (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctrl            (w_ctrl),
            .i_var_index       (i_var_index),
            .i_primary_delta   (i_primary_delta),
            .i_secondary_delta (i_secondary_delta),
            .i_domain_size     (i_domain_size),
            .i_clr_index       (w_ci[NUM_VARS]),
            .i_cand_vld        (w_cv[g]),
            .i_cand_pri        (w_cp[g]),
            .i_cand_sec        (w_cs[g]),
            .i_cand_dom        (w_cd[g]),
            .i_cand_idx        (w_ci[g]),
            .o_cand_vld        (w_cv[g+1]),
            .o_cand_pri        (w_cp[g+1]),
            .o_cand_sec        (w_cs[g+1]),
            .o_cand_dom        (w_cd[g+1]),
            .o_cand_idx        (w_ci[g+1]),
            .o_remaining       (w_flags[g])
        );
    end

    // controller outputs
    always_comb begin
        o_in_ready   = (r_state == bssel_pkg::ST_IDLE);
        w_in_acc     = i_in_valid && o_in_ready;
        w_done       = (r_state == bssel_pkg::ST_SCAN) && (r_cnt == CNT_W'(NUM_VARS))
                       && (!r_out_vld || i_out_ready);
        w_ctrl.load   = w_in_acc && (i_mode == bssel_pkg::MODE_LOAD);
        w_ctrl.adjust = w_in_acc && (i_mode == bssel_pkg::MODE_ADJUST);
        w_ctrl.clear  = w_done && w_cv[NUM_VARS];
    end

    // controller next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            bssel_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (w_in_acc && (i_mode == bssel_pkg::MODE_SELECT)) begin
                    n_state = bssel_pkg::ST_SCAN;
                end
            end
            bssel_pkg::ST_SCAN: begin
                if (r_cnt != CNT_W'(NUM_VARS)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (w_done) begin
                    n_state = bssel_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bssel_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bssel_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_found <= w_cv[NUM_VARS];
            r_out_idx   <= w_cv[NUM_VARS] ?
                           bssel_pkg::SEL_INDEX_BITS'(w_ci[NUM_VARS]) : '0;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_selected_index = r_out_idx;
    assign o_found          = r_out_found;

    // checks
    `BSSEL_ASSERT(a_winner_cleared, i_clk, i_rst_n, w_done && w_cv[NUM_VARS] |=> !w_flags[$past(w_ci[NUM_VARS])], "selected entry still remaining")
    `BSSEL_ASSERT(a_empty_means_none, i_clk, i_rst_n, w_done && !w_cv[NUM_VARS] |-> (w_flags == '0), "not found while entries remain")
    `BSSEL_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(NUM_VARS), "scan counter overrun")
    `BSSEL_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !r_out_vld && (w_flags == '0), "state not cleared by reset")

endmodule

// ===== sv/bssel_cell.sv =====
// ----------------------------------------------------------------------------
// bssel_cell
// One table entry plus one stage of the selection chain. The entry takes
// load and adjust words addressed to it; the chain stage keeps the better
// of the incoming candidate and its own entry and passes it on each cycle.
// ----------------------------------------------------------------------------
module bssel_cell #(
    parameter int CELL_IDX    = 0,
    parameter int NUM_VARS    = 64,
    parameter int SCORE_BITS  = 32,
    parameter int DOMAIN_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  bssel_pkg::t_cell_ctrl                        i_ctrl,
    input  logic [bssel_pkg::VAR_INDEX_BITS-1:0]         i_var_index,
    input  logic signed [bssel_pkg::DELTA_BITS-1:0]      i_primary_delta,
    input  logic signed [bssel_pkg::DELTA_BITS-1:0]      i_secondary_delta,
    input  logic [bssel_pkg::DOMAIN_IN_BITS-1:0]         i_domain_size,
    input  logic [$clog2(NUM_VARS)-1:0]                  i_clr_index,
    input  logic                                         i_cand_vld,
    input  logic signed [SCORE_BITS-1:0]                 i_cand_pri,
    input  logic signed [SCORE_BITS-1:0]                 i_cand_sec,
    input  logic [DOMAIN_BITS-1:0]                       i_cand_dom,
    input  logic [$clog2(NUM_VARS)-1:0]                  i_cand_idx,
    output logic                                         o_cand_vld,
    output logic signed [SCORE_BITS-1:0]                 o_cand_pri,
    output logic signed [SCORE_BITS-1:0]                 o_cand_sec,
    output logic [DOMAIN_BITS-1:0]                       o_cand_dom,
    output logic [$clog2(NUM_VARS)-1:0]                  o_cand_idx,
    output logic                                         o_remaining
);

    localparam int IW = $clog2(NUM_VARS);
    localparam int MW = (IW > bssel_pkg::VAR_INDEX_BITS) ? IW : bssel_pkg::VAR_INDEX_BITS;
    localparam int AW = ((SCORE_BITS > bssel_pkg::DELTA_BITS) ?
                         SCORE_BITS : bssel_pkg::DELTA_BITS) + 1;
    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    // saturating add: out of range when the score's sign bit and the bits above it differ
    function automatic logic signed [SCORE_BITS-1:0] sat_add(
        input logic signed [SCORE_BITS-1:0]            s,
        input logic signed [bssel_pkg::DELTA_BITS-1:0] d
    );
        logic signed [AW-1:0]       sum;
        logic [AW-SCORE_BITS:0]     top;
        sum = AW'(s) + AW'(d);
        top = sum[AW-1:SCORE_BITS-1];
        if ((&top) || !(|top)) begin
            sat_add = sum[SCORE_BITS-1:0];
        end else if (sum[AW-1]) begin
            sat_add = SCORE_MIN;
        end else begin
            sat_add = SCORE_MAX;
        end
    endfunction

    // entry storage
    logic                          r_flag;
    logic signed [SCORE_BITS-1:0]  r_pri;
    logic signed [SCORE_BITS-1:0]  r_sec;
    logic [DOMAIN_BITS-1:0]        r_dom;

    // chain stage
    logic                          r_cv;
    logic signed [SCORE_BITS-1:0]  r_cp;
    logic signed [SCORE_BITS-1:0]  r_cs;
    logic [DOMAIN_BITS-1:0]        r_cd;
    logic [IW-1:0]                 r_ci;

    logic w_hit;
    logic w_clr_hit;
    logic w_own_wins;

    assign w_hit     = (MW'(i_var_index) == MW'(CELL_IDX));
    assign w_clr_hit = (i_clr_index == IW'(CELL_IDX));

    // flag: set on load, cleared when this entry is the selected one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_ctrl.load && w_hit) begin
            r_flag <= 1'b1;
        end else if (i_ctrl.clear && w_clr_hit) begin
            r_flag <= 1'b0;
        end
    end

    // scores and domain size; adjusts only touch a remaining entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && w_hit) begin
            r_pri <= '0;
            r_sec <= '0;
            r_dom <= DOMAIN_BITS'(i_domain_size);
        end else if (i_ctrl.adjust && w_hit && r_flag) begin
            r_pri <= sat_add(r_pri, i_primary_delta);
            r_sec <= sat_add(r_sec, i_secondary_delta);
        end
    end

    // own entry replaces the candidate only when strictly better;
    // full ties keep the incoming, lower-index candidate
    always_comb begin
        w_own_wins = 1'b0;
        if (r_flag) begin
            if (!i_cand_vld) begin
                w_own_wins = 1'b1;
            end else if (r_pri != i_cand_pri) begin
                w_own_wins = (r_pri > i_cand_pri);
            end else if (r_sec != i_cand_sec) begin
                w_own_wins = (r_sec > i_cand_sec);
            end else begin
                w_own_wins = (r_dom > i_cand_dom);
            end
        end
    end

    // chain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= i_cand_vld || r_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_own_wins) begin
            r_cp <= r_pri;
            r_cs <= r_sec;
            r_cd <= r_dom;
            r_ci <= IW'(CELL_IDX);
        end else begin
            r_cp <= i_cand_pri;
            r_cs <= i_cand_sec;
            r_cd <= i_cand_dom;
            r_ci <= i_cand_idx;
        end
    end

    assign o_cand_vld  = r_cv;
    assign o_cand_pri  = r_cp;
    assign o_cand_sec  = r_cs;
    assign o_cand_dom  = r_cd;
    assign o_cand_idx  = r_ci;
    assign o_remaining = r_flag;

endmodule

// ===== sim/tb_best_score_variable_selector.sv =====
// ----------------------------------------------------------------------------
// tb_best_score_variable_selector
// Self-checking bench for the best score variable selector. A directed run
// covers the empty table, saturation at both score bounds, ignored words,
// reloads and every tie-break level. A random run of load / adjust / select
// episodes with random stalls on both channels follows. Each result word is
// checked against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_best_score_variable_selector;
    timeunit 1ns;
    timeprecision 1ps;

    // field widths from the package
    localparam int MODE_BITS      = bssel_pkg::MODE_BITS;
    localparam int VAR_INDEX_BITS = bssel_pkg::VAR_INDEX_BITS;
    localparam int DELTA_BITS     = bssel_pkg::DELTA_BITS;
    localparam int DOMAIN_IN_BITS = bssel_pkg::DOMAIN_IN_BITS;
    localparam int SEL_INDEX_BITS = bssel_pkg::SEL_INDEX_BITS;

    localparam int NUM_VARS = 64;
    localparam int RANDOM_WORDS = 950;
    localparam int QUIET_TAIL = 100;
    localparam int DRAIN_CYCLES = 2 * NUM_VARS + 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [DELTA_BITS-1:0] SCORE_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [DELTA_BITS-1:0] SCORE_BOTTOM = 32'sh8000_0000;

    typedef struct {
        logic [MODE_BITS-1:0]         mode;
        logic [VAR_INDEX_BITS-1:0]    index;
        logic signed [DELTA_BITS-1:0] prim;
        logic signed [DELTA_BITS-1:0] sec;
        logic [DOMAIN_IN_BITS-1:0]    domain;
    } t_word;

    typedef struct {
        logic [SEL_INDEX_BITS-1:0] index;
        logic                      found;
    } t_pick;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [MODE_BITS-1:0] i_mode = '0;
    logic [VAR_INDEX_BITS-1:0] i_var_index = '0;
    logic signed [DELTA_BITS-1:0] i_primary_delta = '0;
    logic signed [DELTA_BITS-1:0] i_secondary_delta = '0;
    logic [DOMAIN_IN_BITS-1:0] i_domain_size = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [SEL_INDEX_BITS-1:0] o_selected_index;
    logic o_found;

    // stimulus and expectation stores
    t_word word_q[$];
    t_pick pick_q[$];
    int    words_total = 0;
    int    words_taken = 0;
    int    errors = 0;
    int    cycles = 0;
    bit    idle_on = 1'b1;
    bit    quiet = 1'b0;

    // table model
    logic signed [DELTA_BITS-1:0] prim_tbl[NUM_VARS];
    logic signed [DELTA_BITS-1:0] sec_tbl[NUM_VARS];
    logic [DOMAIN_IN_BITS-1:0]    dom_tbl[NUM_VARS];
    bit                           live_tbl[NUM_VARS];

    best_score_variable_selector dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_var_index       (i_var_index),
        .i_primary_delta   (i_primary_delta),
        .i_secondary_delta (i_secondary_delta),
        .i_domain_size     (i_domain_size),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_selected_index  (o_selected_index),
        .o_found           (o_found)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // saturating score sum
    function automatic logic signed [DELTA_BITS-1:0] sat_sum(
        input logic signed [DELTA_BITS-1:0] a,
        input logic signed [DELTA_BITS-1:0] d
    );
        longint s;
        s = longint'(a) + longint'(d);
        if (s > longint'(SCORE_TOP)) return SCORE_TOP;
        if (s < longint'(SCORE_BOTTOM)) return SCORE_BOTTOM;
        return s[DELTA_BITS-1:0];
    endfunction

    // ranking: primary, then secondary, then domain size
    function automatic bit outranks(input int a, input int b);
        if (prim_tbl[a] != prim_tbl[b]) return prim_tbl[a] > prim_tbl[b];
        if (sec_tbl[a] != sec_tbl[b]) return sec_tbl[a] > sec_tbl[b];
        return dom_tbl[a] > dom_tbl[b];
    endfunction

    // apply one accepted word to the table; selects queue their result
    task automatic update_table(
        input logic [MODE_BITS-1:0]         mode,
        input logic [VAR_INDEX_BITS-1:0]    index,
        input logic signed [DELTA_BITS-1:0] prim,
        input logic signed [DELTA_BITS-1:0] sec,
        input logic [DOMAIN_IN_BITS-1:0]    domain
    );
        t_pick p;
        bit    have;
        int    best;
        have = 1'b0;
        best = 0;
        if (mode == bssel_pkg::MODE_LOAD) begin
            prim_tbl[index] = '0;
            sec_tbl[index] = '0;
            dom_tbl[index] = domain;
            live_tbl[index] = 1'b1;
        end else if (mode == bssel_pkg::MODE_ADJUST) begin
            if (live_tbl[index]) begin
                prim_tbl[index] = sat_sum(prim_tbl[index], prim);
                sec_tbl[index] = sat_sum(sec_tbl[index], sec);
            end
        end else if (mode == bssel_pkg::MODE_SELECT) begin
            // ascending scan with strict win keeps the lowest index on full ties
            for (int i = 0; i < NUM_VARS; i++) begin
                if (live_tbl[i] && (!have || outranks(i, best))) begin
                    best = i;
                    have = 1'b1;
                end
            end
            if (have) live_tbl[best] = 1'b0;
            p.index = have ? SEL_INDEX_BITS'(best) : '0;
            p.found = have;
            pick_q.push_back(p);
        end
    endtask

    task automatic add_word(
        input logic [MODE_BITS-1:0]         mode,
        input logic [VAR_INDEX_BITS-1:0]    index,
        input logic signed [DELTA_BITS-1:0] prim,
        input logic signed [DELTA_BITS-1:0] sec,
        input logic [DOMAIN_IN_BITS-1:0]    domain
    );
        t_word w;
        w.mode = mode;
        w.index = index;
        w.prim = prim;
        w.sec = sec;
        w.domain = domain;
        word_q.push_back(w);
        words_total++;
    endtask

    // mostly small steps so ties happen, sometimes full range or the bounds
    function automatic logic signed [DELTA_BITS-1:0] rand_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return (int'($urandom_range(0, 6)) - 3) <<< 16;
        if (r < 65) return '0;
        if (r < 85) return $urandom;
        if (r < 92) return SCORE_TOP - $urandom_range(0, 3);
        return SCORE_BOTTOM + $urandom_range(0, 3);
    endfunction

    function automatic logic [DOMAIN_IN_BITS-1:0] rand_domain();
        if ($urandom_range(0, 1)) return DOMAIN_IN_BITS'($urandom_range(1, 4));
        return DOMAIN_IN_BITS'($urandom_range(0, 65535));
    endfunction

    // filler for fields a word does not use
    task automatic add_select();
        add_word(bssel_pkg::MODE_SELECT, VAR_INDEX_BITS'($urandom_range(0, 63)),
                 $urandom, $urandom, DOMAIN_IN_BITS'($urandom));
    endtask

    task automatic add_adjust(input logic [VAR_INDEX_BITS-1:0] index);
        add_word(bssel_pkg::MODE_ADJUST, index, rand_delta(), rand_delta(),
                 DOMAIN_IN_BITS'($urandom));
    endtask

    // input driver
    always @(posedge i_clk) begin
        t_word w;
        int    gap_left;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
            for (int i = 0; i < NUM_VARS; i++) begin
                prim_tbl[i] = '0;
                sec_tbl[i] = '0;
                dom_tbl[i] = '0;
                live_tbl[i] = 1'b0;
            end
        end else begin
            if (i_in_valid && o_in_ready) begin
                update_table(i_mode, i_var_index, i_primary_delta, i_secondary_delta,
                             i_domain_size);
                words_taken++;
                if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
            end
            quiet = (word_q.size() < QUIET_TAIL);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0 && !quiet) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (word_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 14) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    w = word_q.pop_front();
                    i_mode <= w.mode;
                    i_var_index <= w.index;
                    i_primary_delta <= w.prim;
                    i_secondary_delta <= w.sec;
                    i_domain_size <= w.domain;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        int stall_left;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0 && !quiet) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && !quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_pick p;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pick_q.size() == 0) begin
                $error("result word with no select pending: index %0d found %0b",
                       o_selected_index, o_found);
                errors++;
            end else begin
                p = pick_q.pop_front();
                if (o_selected_index !== p.index) begin
                    $error("selected_index: expected %0d, actual %0d", p.index,
                           o_selected_index);
                    errors++;
                end
                if (o_found !== p.found) begin
                    $error("found: expected %0b, actual %0b", p.found, o_found);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int live[$];
        int n_load;
        int n_sel;
        int n_rand;
        n_rand = 0;

        // directed: empty table, ignored words
        add_select();
        add_word(bssel_pkg::MODE_ADJUST, 6'd5, SCORE_TOP, SCORE_TOP, 16'hFFFF);
        add_word(MODE_UNUSED, 6'd63, SCORE_BOTTOM, SCORE_TOP, 16'hFFFF);
        // loads at the index and domain extremes, domain zero included
        add_word(bssel_pkg::MODE_LOAD, 6'd0, '0, '0, 16'hFFFF);
        add_word(bssel_pkg::MODE_LOAD, 6'd63, '0, '0, 16'h0000);
        add_word(bssel_pkg::MODE_LOAD, 6'd31, '0, '0, 16'h0001);
        add_word(bssel_pkg::MODE_LOAD, 6'd32, '0, '0, 16'hFFFF);
        // saturate entry 0 high on primary, low on secondary
        add_word(bssel_pkg::MODE_ADJUST, 6'd0, SCORE_TOP, SCORE_BOTTOM, '0);
        add_word(bssel_pkg::MODE_ADJUST, 6'd0, SCORE_TOP, SCORE_BOTTOM, '0);
        // entry 63 ties on primary, wins on secondary
        add_word(bssel_pkg::MODE_ADJUST, 6'd63, SCORE_TOP, SCORE_TOP, '0);
        add_word(bssel_pkg::MODE_ADJUST, 6'd63, SCORE_TOP, '0, '0);
        add_word(bssel_pkg::MODE_ADJUST, 6'd31, SCORE_BOTTOM, '0, '0);
        add_word(bssel_pkg::MODE_ADJUST, 6'd31, SCORE_BOTTOM, 32'sh0001_0000, '0);
        add_select();
        add_select();
        add_select();
        // reload a remaining entry, reload a selected one, then a full tie
        add_word(bssel_pkg::MODE_LOAD, 6'd31, '0, '0, 16'h8000);
        add_word(bssel_pkg::MODE_LOAD, 6'd32, '0, '0, 16'hFFFF);
        add_word(bssel_pkg::MODE_LOAD, 6'd10, '0, '0, 16'h8000);
        add_select();
        add_select();
        add_select();
        add_select();

        // random episodes: loads, adjusts mostly to live entries, then selects
        while (n_rand < RANDOM_WORDS) begin
            live.delete();
            n_load = $urandom_range(1, 12);
            for (int i = 0; i < n_load; i++) begin
                live.push_back($urandom_range(0, 63));
                add_word(bssel_pkg::MODE_LOAD, VAR_INDEX_BITS'(live[i]), $urandom, $urandom,
                         rand_domain());
                n_rand++;
            end
            repeat ($urandom_range(0, 4 * n_load)) begin
                if ($urandom_range(0, 99) < 85)
                    add_adjust(VAR_INDEX_BITS'(live[$urandom_range(0, live.size() - 1)]));
                else
                    add_adjust(VAR_INDEX_BITS'($urandom_range(0, 63)));
                n_rand++;
            end
            if ($urandom_range(0, 3) == 0)
                add_word(MODE_UNUSED, VAR_INDEX_BITS'($urandom), $urandom, $urandom,
                         DOMAIN_IN_BITS'($urandom));
            n_sel = $urandom_range(1, n_load + 2);
            repeat (n_sel) begin
                add_select();
                n_rand++;
                repeat ($urandom_range(0, 2)) begin
                    add_adjust(VAR_INDEX_BITS'(live[$urandom_range(0, live.size() - 1)]));
                    n_rand++;
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken < words_total) @(posedge i_clk);
        while (pick_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && pick_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
